[rtl/sme_pkg.sv]
package sme_pkg;

    localparam int MOM_BITS       = 24;
    localparam int FIELD_BITS     = 13;
    localparam int SCALE_BITS     = 15;
    localparam int DEN_SCALE_BITS = 27;

    localparam int unsigned NUM_SCALE = 3;

    localparam logic [FIELD_BITS-1:0]     FIELD_RESET = 13'd570;
    localparam logic [DEN_SCALE_BITS-1:0] DEN_SCALE   = 27'd80000000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EQUAL_Z  = 2'd1,
        ST_ZERO_SAG = 2'd2,
        ST_SAT      = 2'd3
    } sme_status_t;

    typedef struct packed {
        logic dz_zero;
        logic n_zero;
        logic charge;
    } sme_flags_t;

    typedef struct packed {
        logic [MOM_BITS-1:0] momentum_mev;
        logic                charge_positive;
        sme_status_t         status;
    } sme_res_t;

endpackage

[rtl/sme_cfg_if.sv]
interface sme_cfg_if import sme_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] field_strength_mt;

    modport source (output valid, output field_strength_mt, input ready);
    modport sink (input valid, input field_strength_mt, output ready);

endinterface

[rtl/sme_pts_if.sv]
interface sme_pts_if #(
    parameter int COORD_WIDTH = 24
) ();

    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] first_y;
    logic [COORD_WIDTH-1:0] first_z;
    logic [COORD_WIDTH-1:0] mid_y;
    logic [COORD_WIDTH-1:0] mid_z;
    logic [COORD_WIDTH-1:0] last_y;
    logic [COORD_WIDTH-1:0] last_z;

    modport source (
        output valid, output first_y, output first_z, output mid_y,
        output mid_z, output last_y, output last_z, input ready
    );
    modport sink (
        input valid, input first_y, input first_z, input mid_y,
        input mid_z, input last_y, input last_z, output ready
    );

endinterface

[rtl/sme_res_if.sv]
interface sme_res_if import sme_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [MOM_BITS-1:0] momentum_mev;
    logic                charge_positive;
    logic [1:0]          status;

    modport source (
        output valid, output momentum_mev, output charge_positive, output status,
        input ready
    );
    modport sink (
        input valid, input momentum_mev, input charge_positive, input status,
        output ready
    );

endinterface

[rtl/sagitta_momentum_estimate_unit.sv]
// Three-point sagitta momentum estimator. Each beat on points carries three y-z track points
// in micrometres; each beat on result returns the momentum in MeV, the charge sign and a
// status code (ok, equal end z, zero sagitta, or saturated at the 24-bit maximum). The unit is
// a fixed pipeline that takes a new beat every cycle while points.ready is high. A beat passes
// through the difference, product and scaling stages, the saturation compare, the
// one-quotient-bit-per-stage divider and the output register. A two-entry output buffer
// keeps the input ready while a finished result waits; points.ready drops only once both
// entries are full.
// The field strength in millitesla is written through cfg, which is always ready, and must
// only be changed while no beat is in flight.
module sagitta_momentum_estimate_unit import sme_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    sme_cfg_if.sink       cfg,
    sme_pts_if.sink       points,
    sme_res_if.source     result
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int SW   = 2 * DW;
    localparam int TW   = DW + SCALE_BITS;
    localparam int NUMW = SW + TW;
    localparam int DENW = SW + DEN_SCALE_BITS;

    logic [FIELD_BITS-1:0] field_reg;
    logic                  en;

    logic                  front_valid;
    logic [SW-1:0]         s_sum;
    logic [TW-1:0]         t_prod;
    logic [SW-1:0]         n_mag;
    sme_flags_t            front_flags;

    logic                  scale_valid;
    logic [NUMW-1:0]       num;
    logic [DENW-1:0]       den;
    sme_flags_t            scale_flags;

    logic                  div_valid;
    logic [MOM_BITS-1:0]   div_quot;
    logic                  div_sat;
    sme_flags_t            div_flags;

    sme_res_t              res_next;
    logic                  out_valid_reg;
    sme_res_t              out_reg;
    logic                  skid_valid_reg;
    sme_res_t              skid_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg <= FIELD_RESET;
        end
        else if (cfg.valid)
        begin
            field_reg <= cfg.field_strength_mt;
        end
    end

    assign en           = !skid_valid_reg;
    assign points.ready = en;

    sme_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_valid          (points.valid),
        .first_y           (points.first_y),
        .first_z           (points.first_z),
        .mid_y             (points.mid_y),
        .mid_z             (points.mid_z),
        .last_y            (points.last_y),
        .last_z            (points.last_z),
        .field_strength_mt (field_reg),
        .out_valid         (front_valid),
        .s_sum             (s_sum),
        .t_prod            (t_prod),
        .n_mag             (n_mag),
        .flags             (front_flags)
    );

    sme_scale #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .s_sum     (s_sum),
        .t_prod    (t_prod),
        .n_mag     (n_mag),
        .in_flags  (front_flags),
        .out_valid (scale_valid),
        .num       (num),
        .den       (den),
        .out_flags (scale_flags)
    );

    sme_div #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (scale_valid),
        .num       (num),
        .den       (den),
        .in_flags  (scale_flags),
        .out_valid (div_valid),
        .quot      (div_quot),
        .sat       (div_sat),
        .out_flags (div_flags)
    );

    always_comb
    begin
        res_next.momentum_mev    = div_quot;
        res_next.charge_positive = div_flags.charge;
        res_next.status          = ST_OK;
        if (div_flags.dz_zero)
        begin
            res_next.momentum_mev    = '0;
            res_next.charge_positive = 1'b0;
            res_next.status          = ST_EQUAL_Z;
        end
        else if (div_flags.n_zero)
        begin
            res_next.momentum_mev    = '0;
            res_next.charge_positive = 1'b0;
            res_next.status          = ST_ZERO_SAG;
        end
        else if (div_sat)
        begin
            res_next.momentum_mev = '1;
            res_next.status       = ST_SAT;
        end
    end

    // The skid entry catches the beat leaving the pipeline while the output beat is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= div_valid;
            end
        end
        else if (en && div_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_next;
        end
        else if (en && div_valid)
        begin
            skid_reg <= res_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.momentum_mev    = out_reg.momentum_mev;
    assign result.charge_positive = out_reg.charge_positive;
    assign result.status          = out_reg.status;

    a_skid_needs_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result.valid
    ) else $error("skid entry held while output is empty");

    a_skid_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(result.valid && !result.ready)
    ) else $error("skid entry filled without an output stall");

    a_sat_value: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_SAT) |-> (result.momentum_mev == '1)
    ) else $error("saturated result without maximum momentum");

    a_flagged_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == ST_EQUAL_Z || result.status == ST_ZERO_SAG))
            |-> (result.momentum_mev == '0 && !result.charge_positive)
    ) else $error("flagged result carries momentum or charge");

endmodule

[rtl/sme_front.sv]
module sme_front import sme_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [COORD_WIDTH-1:0]             first_y,
    input  logic [COORD_WIDTH-1:0]             first_z,
    input  logic [COORD_WIDTH-1:0]             mid_y,
    input  logic [COORD_WIDTH-1:0]             mid_z,
    input  logic [COORD_WIDTH-1:0]             last_y,
    input  logic [COORD_WIDTH-1:0]             last_z,
    input  logic [FIELD_BITS-1:0]              field_strength_mt,
    output logic                               out_valid,
    output logic [2*COORD_WIDTH+1:0]           s_sum,
    output logic [COORD_WIDTH+SCALE_BITS:0]    t_prod,
    output logic [2*COORD_WIDTH+1:0]           n_mag,
    output sme_flags_t                         flags
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int TW = DW + SCALE_BITS;

    logic signed [DW-1:0] dy_next, dz_next, ay_next, az_next;
    logic                 valid_a_reg;
    logic signed [DW-1:0] dy_reg, dz_reg, ay_reg, az_reg;

    logic                 valid_b_reg;
    logic signed [PW-1:0] pn1_reg, pn2_reg, sqy_reg, sqz_reg;
    logic [DW-1:0]        dzm_b_reg;
    logic                 dzn_b_reg;
    logic                 dzz_b_reg;

    logic [SCALE_BITS-1:0] scale;
    logic                  valid_c_reg;
    logic signed [PW:0]    n_reg;
    logic [PW-1:0]         s_c_reg;
    logic [TW-1:0]         t_c_reg;
    logic                  dzn_c_reg;
    logic                  dzz_c_reg;

    logic                  valid_d_reg;
    logic [PW-1:0]         nmag_reg;
    logic [PW-1:0]         s_d_reg;
    logic [TW-1:0]         t_d_reg;
    sme_flags_t            flags_d_reg;

    always_comb
    begin
        dy_next = $signed({last_y[COORD_WIDTH-1], last_y})
                - $signed({first_y[COORD_WIDTH-1], first_y});
        dz_next = $signed({last_z[COORD_WIDTH-1], last_z})
                - $signed({first_z[COORD_WIDTH-1], first_z});
        ay_next = $signed({mid_y[COORD_WIDTH-1], mid_y})
                - $signed({first_y[COORD_WIDTH-1], first_y});
        az_next = $signed({mid_z[COORD_WIDTH-1], mid_z})
                - $signed({first_z[COORD_WIDTH-1], first_z});
        scale   = SCALE_BITS'(NUM_SCALE) * SCALE_BITS'(field_strength_mt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dy_reg <= dy_next;
            dz_reg <= dz_next;
            ay_reg <= ay_next;
            az_reg <= az_next;

            pn1_reg   <= ay_reg * dz_reg;
            pn2_reg   <= az_reg * dy_reg;
            sqy_reg   <= dy_reg * dy_reg;
            sqz_reg   <= dz_reg * dz_reg;
            dzm_b_reg <= dz_reg[DW-1] ? DW'(-dz_reg) : DW'(dz_reg);
            dzn_b_reg <= dz_reg[DW-1];
            dzz_b_reg <= (dz_reg == '0);

            n_reg     <= pn1_reg - pn2_reg;
            s_c_reg   <= PW'(sqy_reg[PW-2:0]) + PW'(sqz_reg[PW-2:0]);
            t_c_reg   <= TW'(dzm_b_reg) * TW'(scale);
            dzn_c_reg <= dzn_b_reg;
            dzz_c_reg <= dzz_b_reg;

            nmag_reg            <= n_reg[PW] ? PW'(-n_reg) : PW'(n_reg);
            s_d_reg             <= s_c_reg;
            t_d_reg             <= t_c_reg;
            flags_d_reg.dz_zero <= dzz_c_reg;
            flags_d_reg.n_zero  <= (n_reg == '0);
            flags_d_reg.charge  <= n_reg[PW] ^ dzn_c_reg;
        end
    end

    assign out_valid = valid_d_reg;
    assign s_sum     = s_d_reg;
    assign t_prod    = t_d_reg;
    assign n_mag     = nmag_reg;
    assign flags     = flags_d_reg;

endmodule

[rtl/sme_scale.sv]
module sme_scale import sme_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            en,
    input  logic                                            in_valid,
    input  logic [2*COORD_WIDTH+1:0]                        s_sum,
    input  logic [COORD_WIDTH+SCALE_BITS:0]                 t_prod,
    input  logic [2*COORD_WIDTH+1:0]                        n_mag,
    input  sme_flags_t                                      in_flags,
    output logic                                            out_valid,
    output logic [3*COORD_WIDTH+SCALE_BITS+2:0]             num,
    output logic [2*COORD_WIDTH+DEN_SCALE_BITS+1:0]         den,
    output sme_flags_t                                      out_flags
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int SW   = 2 * DW;
    localparam int TW   = DW + SCALE_BITS;
    localparam int TH   = TW / 2;
    localparam int TU   = TW - TH;
    localparam int SUMW = DW + TW;
    localparam int NUMW = SW + TW;
    localparam int DPW  = DW + DEN_SCALE_BITS;
    localparam int DENW = SW + DEN_SCALE_BITS;

    logic [DW-1:0]      s_lo, s_hi, n_lo, n_hi;
    logic [TH-1:0]      t_lo;
    logic [TU-1:0]      t_hi;

    logic               valid_e_reg;
    logic [DW+TH-1:0]   p00_reg, p10_reg;
    logic [DW+TU-1:0]   p01_reg, p11_reg;
    logic [DPW-1:0]     d0_reg, d1_reg;
    sme_flags_t         flags_e_reg;

    logic               valid_f_reg;
    logic [SUMW-1:0]    sum_lo_reg, sum_hi_reg;
    logic [DENW-1:0]    den_f_reg;
    sme_flags_t         flags_f_reg;

    logic               valid_g_reg;
    logic [NUMW-1:0]    num_reg;
    logic [DENW-1:0]    den_g_reg;
    sme_flags_t         flags_g_reg;

    always_comb
    begin
        s_lo = s_sum[DW-1:0];
        s_hi = s_sum[SW-1:DW];
        n_lo = n_mag[DW-1:0];
        n_hi = n_mag[SW-1:DW];
        t_lo = t_prod[TH-1:0];
        t_hi = t_prod[TW-1:TH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_e_reg <= 1'b0;
            valid_f_reg <= 1'b0;
            valid_g_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_e_reg <= in_valid;
            valid_f_reg <= valid_e_reg;
            valid_g_reg <= valid_f_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg     <= (DW+TH)'(s_lo) * (DW+TH)'(t_lo);
            p01_reg     <= (DW+TU)'(s_lo) * (DW+TU)'(t_hi);
            p10_reg     <= (DW+TH)'(s_hi) * (DW+TH)'(t_lo);
            p11_reg     <= (DW+TU)'(s_hi) * (DW+TU)'(t_hi);
            d0_reg      <= DPW'(n_lo) * DPW'(DEN_SCALE);
            d1_reg      <= DPW'(n_hi) * DPW'(DEN_SCALE);
            flags_e_reg <= in_flags;

            sum_lo_reg  <= SUMW'(p00_reg) + (SUMW'(p01_reg) << TH);
            sum_hi_reg  <= SUMW'(p10_reg) + (SUMW'(p11_reg) << TH);
            den_f_reg   <= DENW'(d0_reg) + (DENW'(d1_reg) << DW);
            flags_f_reg <= flags_e_reg;

            num_reg     <= NUMW'(sum_lo_reg) + (NUMW'(sum_hi_reg) << DW);
            den_g_reg   <= den_f_reg;
            flags_g_reg <= flags_f_reg;
        end
    end

    assign out_valid = valid_g_reg;
    assign num       = num_reg;
    assign den       = den_g_reg;
    assign out_flags = flags_g_reg;

endmodule

[rtl/sme_div.sv]
module sme_div import sme_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            en,
    input  logic                                            in_valid,
    input  logic [3*COORD_WIDTH+SCALE_BITS+2:0]             num,
    input  logic [2*COORD_WIDTH+DEN_SCALE_BITS+1:0]         den,
    input  sme_flags_t                                      in_flags,
    output logic                                            out_valid,
    output logic [MOM_BITS-1:0]                             quot,
    output logic                                            sat,
    output sme_flags_t                                      out_flags
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int NUMW = 2 * DW + DW + SCALE_BITS;
    localparam int DENW = 2 * DW + DEN_SCALE_BITS;
    localparam int RW   = (NUMW > DENW + MOM_BITS) ? NUMW : DENW + MOM_BITS;

    logic [RW-1:0]       num_x, lim;

    logic                valid_reg [0:MOM_BITS];
    logic [MOM_BITS-1:0] q_reg     [0:MOM_BITS];
    logic                sat_reg   [0:MOM_BITS];
    sme_flags_t          flags_reg [0:MOM_BITS];
    logic [RW-1:0]       rem_reg   [0:MOM_BITS-1];
    logic [DENW-1:0]     den_reg   [0:MOM_BITS-1];

    always_comb
    begin
        num_x = RW'(num);
        lim   = RW'(den) << MOM_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= num_x;
            den_reg[0]   <= den;
            q_reg[0]     <= '0;
            sat_reg[0]   <= (num_x >= lim);
            flags_reg[0] <= in_flags;
        end
    end

    for (genvar j = 0; j < MOM_BITS; j++)
    begin : g_bit
        logic [RW-1:0] trial;
        logic          fits;

        always_comb
        begin
            trial = RW'(den_reg[j]) << (MOM_BITS - 1 - j);
            fits  = (rem_reg[j] >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j+1]     <= {q_reg[j][MOM_BITS-2:0], fits};
                sat_reg[j+1]   <= sat_reg[j];
                flags_reg[j+1] <= flags_reg[j];
            end
        end

        if (j < MOM_BITS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= fits ? (rem_reg[j] - trial) : rem_reg[j];
                    den_reg[j+1] <= den_reg[j];
                end
            end
        end
    end

    assign out_valid = valid_reg[MOM_BITS];
    assign quot      = q_reg[MOM_BITS];
    assign sat       = sat_reg[MOM_BITS];
    assign out_flags = flags_reg[MOM_BITS];

endmodule

[tb/sme_momentum_checker.sv]
module sme_momentum_checker import sme_pkg::*; #(
    parameter int COORD_W = 24
) (
    input  logic clk,
    input  logic rst_n,
    sme_cfg_if   cfg,
    sme_pts_if   points,
    sme_res_if   result,
    output int   fail_count,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [FIELD_BITS-1:0] field_mt;
    sme_res_t              pending_estimates[$];

    function automatic sme_res_t estimate_momentum(
        input logic [COORD_W-1:0]    fy,
        input logic [COORD_W-1:0]    fz,
        input logic [COORD_W-1:0]    my,
        input logic [COORD_W-1:0]    mz,
        input logic [COORD_W-1:0]    ly,
        input logic [COORD_W-1:0]    lz,
        input logic [FIELD_BITS-1:0] field
    );
        logic signed [127:0] dy;
        logic signed [127:0] dz;
        logic signed [127:0] sag_num;
        logic [127:0]        dy_mag;
        logic [127:0]        dz_mag;
        logic [127:0]        sag_mag;
        logic [127:0]        numer;
        logic [127:0]        denom;
        logic [127:0]        quot;
        sme_res_t            est;
        est.momentum_mev    = '0;
        est.charge_positive = 1'b0;
        est.status          = ST_OK;
        dy = $signed(ly) - $signed(fy);
        dz = $signed(lz) - $signed(fz);
        sag_num = ($signed(my) - $signed(fy)) * dz - ($signed(mz) - $signed(fz)) * dy;
        if (dz == 0)
        begin
            est.status = ST_EQUAL_Z;
        end
        else if (sag_num == 0)
        begin
            est.status = ST_ZERO_SAG;
        end
        else
        begin
            dy_mag  = (dy < 0) ? -dy : dy;
            dz_mag  = (dz < 0) ? -dz : dz;
            sag_mag = (sag_num < 0) ? -sag_num : sag_num;
            numer = (dy_mag * dy_mag + dz_mag * dz_mag) * dz_mag * (NUM_SCALE * field);
            denom = sag_mag * DEN_SCALE;
            quot  = numer / denom;
            est.charge_positive = (sag_num < 0) != (dz < 0);
            if (quot >= (128'd1 << MOM_BITS))
            begin
                est.momentum_mev = '1;
                est.status       = ST_SAT;
            end
            else
            begin
                est.momentum_mev = quot[MOM_BITS-1:0];
            end
        end
        return est;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int       errs;
        sme_res_t want;
        errs = 0;
        if (!rst_n)
        begin
            field_mt = FIELD_RESET;
            pending_estimates.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                field_mt = cfg.field_strength_mt;
            end
            if (result.valid && result.ready)
            begin
                if (pending_estimates.size() == 0)
                begin
                    $error({"unexpected result beat: momentum_mev %0d, ",
                            "charge_positive %0d, status %0d"},
                           result.momentum_mev, result.charge_positive, result.status);
                    errs++;
                end
                else
                begin
                    want = pending_estimates.pop_front();
                    if (result.momentum_mev !== want.momentum_mev)
                    begin
                        $error("momentum_mev mismatch: expected %0d, actual %0d",
                               want.momentum_mev, result.momentum_mev);
                        errs++;
                    end
                    if (result.charge_positive !== want.charge_positive)
                    begin
                        $error("charge_positive mismatch: expected %0d, actual %0d",
                               want.charge_positive, result.charge_positive);
                        errs++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, result.status);
                        errs++;
                    end
                end
            end
            if (points.valid && points.ready)
            begin
                pending_estimates = {pending_estimates, estimate_momentum(
                    points.first_y, points.first_z, points.mid_y, points.mid_z,
                    points.last_y, points.last_z, field_mt)};
            end
            fail_count  <= fail_count + errs;
            outstanding <= pending_estimates.size();
        end
    end

endmodule

[tb/sagitta_momentum_estimate_unit_tb.sv]
module sagitta_momentum_estimate_unit_tb import sme_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W        = 24;
    localparam int MAXC           = 8388607;
    localparam int MINC           = -8388608;
    localparam int RESET_CYCLES   = 5;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] first_z;
        logic [COORD_W-1:0] mid_y;
        logic [COORD_W-1:0] mid_z;
        logic [COORD_W-1:0] last_y;
        logic [COORD_W-1:0] last_z;
    } track_pts_t;

    logic clk          = 1'b0;
    logic rst_n        = 1'b0;
    logic hold_request = 1'b0;
    logic steady       = 1'b0;
    int   fail_count;
    int   outstanding;

    sme_cfg_if                            cfg_bus ();
    sme_pts_if #(.COORD_WIDTH(COORD_W))   pts_bus ();
    sme_res_if                            res_bus ();

    sagitta_momentum_estimate_unit #(.COORD_WIDTH(COORD_W)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .points (pts_bus),
        .result (res_bus)
    );

    sme_momentum_checker #(.COORD_W(COORD_W)) momentum_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_bus),
        .points      (pts_bus),
        .result      (res_bus),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int rand_signed(input int w);
        int v;
        v = $urandom;
        v = v <<< (32 - w);
        return v >>> (32 - w);
    endfunction

    function automatic track_pts_t track_of(input int fy, input int fz, input int my,
                                            input int mz, input int ly, input int lz);
        track_pts_t t;
        t.first_y = COORD_W'(fy);
        t.first_z = COORD_W'(fz);
        t.mid_y   = COORD_W'(my);
        t.mid_z   = COORD_W'(mz);
        t.last_y  = COORD_W'(ly);
        t.last_z  = COORD_W'(lz);
        return t;
    endfunction

    function automatic track_pts_t random_track();
        int         kind;
        int         fy;
        int         fz;
        int         dy;
        int         dz;
        int         near;
        int         far;
        track_pts_t t;
        kind = $urandom_range(0, 99);
        fy   = rand_signed(24);
        fz   = rand_signed(24);
        if (kind < 60)
        begin
            dy = rand_signed($urandom_range(1, 22));
            dz = rand_signed($urandom_range(1, 23));
            t = track_of(fy, fz, fy + dy / 2 + rand_signed($urandom_range(1, 14)),
                         fz + dz / 2 + rand_signed($urandom_range(1, 8)), fy + dy, fz + dz);
        end
        else if (kind < 70)
        begin
            t = track_of(fy, fz, rand_signed(24), rand_signed(24), rand_signed(24), fz);
        end
        else if (kind < 80)
        begin
            fy   = rand_signed(20);
            fz   = rand_signed(20);
            dy   = rand_signed($urandom_range(1, 10));
            dz   = rand_signed($urandom_range(1, 10));
            near = $urandom_range(1, 4);
            far  = $urandom_range(5, 8);
            t = track_of(fy, fz, fy + near * dy, fz + near * dz, fy + far * dy, fz + far * dz);
        end
        else
        begin
            t = track_of(fy, fz, rand_signed(24), rand_signed(24), rand_signed(24),
                         rand_signed(24));
        end
        return t;
    endfunction

    task automatic send_track(input track_pts_t t);
        int gap;
        pts_bus.valid   <= 1'b1;
        pts_bus.first_y <= t.first_y;
        pts_bus.first_z <= t.first_z;
        pts_bus.mid_y   <= t.mid_y;
        pts_bus.mid_z   <= t.mid_z;
        pts_bus.last_y  <= t.last_y;
        pts_bus.last_z  <= t.last_z;
        @(posedge clk);
        while (!pts_bus.ready)
        begin
            @(posedge clk);
        end
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            pts_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(input int count);
        repeat (count) send_track(random_track());
    endtask

    task automatic settle();
        pts_bus.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_field(input logic [FIELD_BITS-1:0] field);
        cfg_bus.valid             <= 1'b1;
        cfg_bus.field_strength_mt <= field;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_curved_set();
        send_track(track_of(0, 0, 50, 500000, 0, 1000000));
        send_track(track_of(0, 1000000, -50, 500000, 0, 0));
        send_track(track_of(0, 0, 1, 500000, 0, 1000000));
    endtask

    task automatic send_directed();
        send_track(track_of(0, 0, 0, 0, 0, 0));
        send_track(track_of(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
        send_track(track_of(MINC, MINC, MINC, MINC, MINC, MINC));
        send_track(track_of(100, 5000, -300, 0, 7, 5000));
        send_track(track_of(0, 0, 100, 100, 200, 200));
        send_track(track_of(1000, -2000, 500, -1000, 0, 0));
        send_track(track_of(0, 0, 50, 500000, 0, 1000000));
        send_track(track_of(0, 0, -50, 500000, 0, 1000000));
        send_track(track_of(0, 1000000, 50, 500000, 0, 0));
        send_track(track_of(0, 1000000, -50, 500000, 0, 0));
        send_track(track_of(0, 0, 1, 500000, 0, 1000000));
        send_track(track_of(MINC, MINC, 0, 0, MAXC, MAXC));
        send_track(track_of(MINC, MINC, 1, 0, MAXC, MAXC));
        send_track(track_of(MAXC, MAXC, MINC, 0, MINC, MINC));
        send_track(track_of(MINC, MAXC, MAXC, 0, MINC, MINC));
        send_track(track_of(MAXC, MINC, MINC, MAXC, MAXC, MAXC));
        send_track(track_of(0, 0, 0, 1, 1, 2));
        send_track(track_of(0, 0, -1, 0, 0, 1));
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left    = 0;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                stall_left = HOLD_CYCLES;
                hold_request <= 1'b0;
            end
            else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pts_bus.valid && pts_bus.ready) || (res_bus.valid && res_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("sagitta_momentum_estimate_unit_tb failed");
        $finish;
    end

    initial
    begin
        cfg_bus.valid             <= 1'b0;
        cfg_bus.field_strength_mt <= '0;
        pts_bus.valid             <= 1'b0;
        pts_bus.first_y           <= '0;
        pts_bus.first_z           <= '0;
        pts_bus.mid_y             <= '0;
        pts_bus.mid_z             <= '0;
        pts_bus.last_y            <= '0;
        pts_bus.last_z            <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        send_random(100);
        settle();

        write_field(FIELD_BITS'(8191));
        send_curved_set();
        steady = 1'b1;
        send_random(40);
        steady = 1'b0;
        settle();
        // The result side holds off while points keep coming until the input stalls.
        hold_request <= 1'b1;
        steady = 1'b1;
        send_random(80);
        steady = 1'b0;
        send_random(40);
        settle();

        write_field('0);
        send_curved_set();
        send_random(40);
        settle();

        write_field(FIELD_BITS'(1));
        send_random(40);
        settle();

        write_field(FIELD_BITS'($urandom_range(2, 8190)));
        send_random(60);
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("sagitta_momentum_estimate_unit_tb passed");
        end
        else
        begin
            $display("sagitta_momentum_estimate_unit_tb failed");
        end
        $finish;
    end

endmodule
